@@ rtl/core/oahs_pkg.sv @@
// ----------------------------------------------------------------------------
// oahs_pkg
// Types and codes for the hash set block; its channel interfaces use matching widths.
// ----------------------------------------------------------------------------
package oahs_pkg;

  localparam int unsigned HASH_BITS = 64;
  localparam int unsigned CNT_BITS  = 11;
  localparam int unsigned LG_BITS   = 4;
  localparam int unsigned LG_MIN    = 3;
  localparam int unsigned LG_RESET  = 10;
  localparam int unsigned PROBE_EXTRA = 16;

  typedef enum logic [1:0] {
    REQ_CONTAINS = 2'd0,
    REQ_REMOVE   = 2'd1,
    REQ_ADD      = 2'd2,
    REQ_POP      = 2'd3
  } req_t;

  typedef enum logic [1:0] {
    ST_DONE   = 2'd0,
    ST_ABSENT = 2'd1,
    ST_FULL   = 2'd2,
    ST_EMPTY  = 2'd3
  } status_t;

  typedef enum logic [1:0] {
    MARK_EMPTY = 2'd0,
    MARK_TOMB  = 2'd1,
    MARK_LIVE  = 2'd2,
    MARK_RSVD  = 2'd3
  } mark_t;

endpackage

@@ rtl/core/oahs_if.sv @@
// ----------------------------------------------------------------------------
// oahs_req_if / oahs_rsp_if / oahs_cfg_if
// Valid/ready channels for requests, results and the size register.
// ----------------------------------------------------------------------------
interface oahs_req_if #(parameter int unsigned KEY_BITS = 64);
  logic                  valid;
  logic                  ready;
  logic [1:0]            req_type;
  logic [KEY_BITS-1:0]   item_key;
  logic signed [63:0]    item_hash;
  modport source (output valid, req_type, item_key, item_hash, input ready);
  modport sink   (input valid, req_type, item_key, item_hash, output ready);
endinterface

interface oahs_rsp_if #(parameter int unsigned KEY_BITS = 64);
  logic                valid;
  logic                ready;
  logic                was_present;
  logic [1:0]          status;
  logic [KEY_BITS-1:0] popped_key;
  logic [10:0]         live_count;
  logic [10:0]         used_count;
  logic                load_high;
  modport source (output valid, was_present, status, popped_key, live_count,
                  used_count, load_high, input ready);
  modport sink   (input valid, was_present, status, popped_key, live_count,
                  used_count, load_high, output ready);
endinterface

interface oahs_cfg_if;
  logic       valid;
  logic       ready;
  logic [3:0] data;
  modport source (output valid, data, input ready);
  modport sink   (input valid, data, output ready);
endinterface

@@ rtl/core/open_address_hash_set.sv @@
// ----------------------------------------------------------------------------
// open_address_hash_set
// Open-addressing hash set with perturbation probing over a slot memory.
// ----------------------------------------------------------------------------
// One request is handled at a time; the request is taken in S_IDLE.
// Each probe reads the slot memory in S_READ and compares in S_EVAL.
// Moving on to the next probe goes through S_STEP. Write-back and result
// loading take S_WRITE and S_DONE. Pop scans from slot 0, one slot per
// probe and with no S_STEP, until it finds a live one or has read the
// last slot. A result that waits for the previous result's transfer holds
// the block in S_DONE. After reset a clearing pass marks all
// 2**SLOT_LOG2_MAX slots empty, one per cycle, before the first request is
// taken. The result register frees the request side once it is loaded.
module open_address_hash_set #(
  parameter int unsigned SLOT_LOG2_MAX = 10,
  parameter int unsigned KEY_BITS      = 64
) (
  input  logic clk,
  input  logic rst,
  oahs_req_if.sink   req,
  oahs_rsp_if.source rsp,
  oahs_cfg_if.sink   cfg
);

  localparam int unsigned DEPTH = 1 << SLOT_LOG2_MAX;
  localparam int unsigned AW    = SLOT_LOG2_MAX;
  localparam int unsigned BW    = SLOT_LOG2_MAX + 2;  // probe budget counter
  localparam int unsigned CNT_BITS_L = oahs_pkg::CNT_BITS;

  typedef enum logic [6:0] {
    S_CLEAR = 7'b0000001,
    S_IDLE  = 7'b0000010,
    S_READ  = 7'b0000100,
    S_EVAL  = 7'b0001000,
    S_STEP  = 7'b0010000,
    S_WRITE = 7'b0100000,
    S_DONE  = 7'b1000000
  } state_t;

  // slot memory
  logic [1:0]          mark_mem [DEPTH];
  logic [KEY_BITS-1:0] key_mem  [DEPTH];
  logic [63:0]         hash_mem [DEPTH];
  logic [1:0]          rd_mark;
  logic [KEY_BITS-1:0] rd_key;
  logic [63:0]         rd_hash;

  state_t state;
  logic [3:0]          size_lg;
  logic [AW-1:0]       idx;
  logic [AW-1:0]       mask;
  logic [63:0]         perturb;
  logic [BW-1:0]       probes;
  logic [BW-1:0]       budget;
  logic                tomb_seen;
  logic [AW-1:0]       tomb_idx;
  logic [1:0]          op;
  logic [KEY_BITS-1:0] key;
  logic [63:0]         hash;
  logic [CNT_BITS_L-1:0] live_total, used_total;
  logic                wr_en;
  logic [AW-1:0]       wr_idx;
  logic [1:0]          wr_mark;
  logic                wr_data;
  logic                hit;
  logic [AW-1:0]       step_idx;
  logic [3:0]          lg_eff;
  logic [AW:0]         cap;
  logic [AW+2:0]       two_third;
  logic                res_present;
  oahs_pkg::status_t   res_status;
  logic [KEY_BITS-1:0] res_popped;

  // effective size and derived mask, probe budget and load threshold
  always_comb begin
    lg_eff = size_lg;
    if (size_lg < 4'(oahs_pkg::LG_MIN)) lg_eff = 4'(oahs_pkg::LG_MIN);
    if (32'(size_lg) > SLOT_LOG2_MAX) lg_eff = 4'(SLOT_LOG2_MAX);
    cap       = (AW+1)'(1) << lg_eff;
    mask      = AW'(cap - 1'b1);
    budget    = BW'(cap) + BW'(oahs_pkg::PROBE_EXTRA);
    // floor(2*cap/3) is the alternating bit pattern 1010... cut to lg_eff bits
    two_third = (AW+3)'(32'hAAAA_AAAA >> (6'd32 - 6'(lg_eff)));
  end

  assign hit = (rd_mark == oahs_pkg::MARK_LIVE) && (rd_hash == hash) && (rd_key == key);
  assign step_idx = AW'((idx * 5) + AW'(perturb >> 5) + 1'b1) & mask;

  // memory: one read port, one write port, registered read
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mark_mem[wr_idx] <= wr_mark;
      if (wr_data) begin
        key_mem[wr_idx]  <= key;
        hash_mem[wr_idx] <= hash;
      end
    end
    rd_mark <= mark_mem[idx];
    rd_key  <= key_mem[idx];
    rd_hash <= hash_mem[idx];
  end

  assign req.ready = (state == S_IDLE);
  assign cfg.ready = 1'b1;

  // sequencer
  always_ff @(posedge clk) begin
    wr_en   <= 1'b0;
    wr_data <= 1'b0;
    if (rst) begin
      state      <= S_CLEAR;
      idx        <= '0;
      size_lg    <= 4'(oahs_pkg::LG_RESET);
      live_total <= '0;
      used_total <= '0;
      rsp.valid  <= 1'b0;
      wr_en      <= 1'b1;
      wr_idx     <= '0;
      wr_mark    <= oahs_pkg::MARK_EMPTY;
    end else begin
      if (cfg.valid) size_lg <= cfg.data;
      if (rsp.valid && rsp.ready) rsp.valid <= 1'b0;
      case (state)
        S_CLEAR: begin
          // sweep every slot to empty
          wr_en   <= 1'b1;
          wr_mark <= oahs_pkg::MARK_EMPTY;
          wr_idx  <= wr_idx + 1'b1;
          if (&wr_idx) begin
            wr_en <= 1'b0;
            state <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (req.valid) begin
            op        <= req.req_type;
            key       <= req.item_key;
            hash      <= req.item_hash;
            perturb   <= req.item_hash;
            probes    <= '0;
            tomb_seen <= 1'b0;
            if (req.req_type == oahs_pkg::REQ_POP) idx <= '0;
            else idx <= AW'(req.item_hash) & mask;
            state <= S_READ;
          end
        end
        S_READ: state <= S_EVAL;
        S_EVAL: begin
          res_popped  <= '0;
          res_present <= 1'b0;
          res_status  <= oahs_pkg::ST_DONE;
          state       <= S_WRITE;
          if (op == oahs_pkg::REQ_POP) begin
            if (rd_mark == oahs_pkg::MARK_LIVE) begin
              wr_en <= 1'b1; wr_idx <= idx; wr_mark <= oahs_pkg::MARK_TOMB;
              live_total  <= live_total - 1'b1;
              res_popped  <= rd_key;
              res_present <= 1'b1;
            end else if (&idx) begin
              res_status <= oahs_pkg::ST_EMPTY;
            end else begin
              idx <= idx + 1'b1;
              state <= S_READ;
            end
          end else if (hit) begin
            res_present <= 1'b1;
            if (op == oahs_pkg::REQ_REMOVE) begin
              wr_en <= 1'b1; wr_idx <= idx; wr_mark <= oahs_pkg::MARK_TOMB;
              live_total <= live_total - 1'b1;
            end
          end else if (rd_mark == oahs_pkg::MARK_EMPTY ||
                       probes == budget - 1'b1) begin
            // probe ends: place an add, report a full table or report absence
            if (op == oahs_pkg::REQ_ADD) begin
              if (tomb_seen || rd_mark != oahs_pkg::MARK_LIVE) begin
                wr_en <= 1'b1; wr_data <= 1'b1;
                wr_mark <= oahs_pkg::MARK_LIVE;
                live_total <= live_total + 1'b1;
                if (tomb_seen) wr_idx <= tomb_idx;
                else begin
                  // last probe landed on an empty slot or the first tombstone
                  wr_idx <= idx;
                  if (rd_mark == oahs_pkg::MARK_EMPTY) used_total <= used_total + 1'b1;
                end
              end else begin
                res_status <= oahs_pkg::ST_FULL;
              end
            end else begin
              res_status <= oahs_pkg::ST_ABSENT;
            end
          end else begin
            if (rd_mark == oahs_pkg::MARK_TOMB && !tomb_seen) begin
              tomb_seen <= 1'b1;
              tomb_idx  <= idx;
            end
            state <= S_STEP;
          end
        end
        S_STEP: begin
          // advance the probe sequence
          idx     <= step_idx;
          perturb <= perturb >> 5;
          probes  <= probes + 1'b1;
          state   <= S_READ;
        end
        S_WRITE: state <= S_DONE;
        S_DONE: begin
          // load the result once the previous one has been transferred
          if (!rsp.valid || rsp.ready) begin
            rsp.valid       <= 1'b1;
            rsp.was_present <= res_present;
            rsp.status      <= res_status;
            rsp.popped_key  <= res_popped;
            rsp.live_count  <= live_total;
            rsp.used_count  <= used_total;
            rsp.load_high   <= (AW+3)'(used_total) > two_third;
            state           <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // checks
  a_live_le_used: assert property (@(posedge clk) disable iff (rst)
    live_total <= used_total) else $error("live count above used count");
  a_no_req_busy: assert property (@(posedge clk) disable iff (rst)
    (state != S_IDLE) |-> !req.ready) else $error("ready while busy");
  a_used_mono: assert property (@(posedge clk) disable iff (rst)
    (state != S_CLEAR) |=> used_total >= $past(used_total))
    else $error("used count fell");

endmodule
